FILE: design/crc_pkg.sv
package crc_pkg;

  localparam int unsigned POLY_W     = 32;
  localparam int unsigned DEGREE_W   = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POLY_LOW    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = 1'd1;

  localparam logic [POLY_W-1:0]   POLY_LOW_RESET = 32'h04C1_1DB7;
  localparam logic [DEGREE_W-1:0] DEGREE_RESET   = 6'd32;

  typedef struct packed {
    logic [POLY_W-1:0]   poly_low;
    logic [DEGREE_W-1:0] degree;
  } cfg_t;

endpackage

FILE: design/crc_if.sv
interface crc_in_if;
  logic valid;
  logic ready;
  logic msg_bit;
  logic msg_last;

  modport source (output valid, output msg_bit, output msg_last, input ready);
  modport sink (input valid, input msg_bit, input msg_last, output ready);
endinterface

interface crc_out_if;
  logic valid;
  logic ready;
  logic code_bit;
  logic is_check_bit;
  logic code_last;

  modport source (output valid, output code_bit, output is_check_bit, output code_last,
                  input ready);
  modport sink (input valid, input code_bit, input is_check_bit, input code_last,
                output ready);
endinterface

FILE: design/crc_fifo.sv
module crc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: design/crc_front.sv
module crc_front #(
  parameter int unsigned MAX_DEGREE = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  crc_pkg::cfg_t          cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   msg_bit_i,
  input  logic                   msg_last_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output logic [MAX_DEGREE+$clog2(MAX_DEGREE+1)+1:0] q_wdata_o
);
  import crc_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned PW = (MAX_DEGREE < POLY_W) ? MAX_DEGREE : POLY_W;

  logic [MAX_DEGREE-1:0] rem_q, rem_d;
  logic [MAX_DEGREE-1:0] rem_next;
  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] poly_ext;
  logic [6:0]            deg_sat;
  logic [DW-1:0]         deg;
  logic                  fb;
  logic                  accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;

  // clamp the programmed degree to 1..MAX_DEGREE
  always_comb begin
    deg_sat = {1'b0, cfg_i.degree};
    if (deg_sat == 7'd0) begin
      deg_sat = 7'd1;
    end
    if (deg_sat > 7'(MAX_DEGREE)) begin
      deg_sat = 7'(MAX_DEGREE);
    end
    deg = DW'(deg_sat);
  end

  always_comb begin
    poly_ext = '0;
    poly_ext[PW-1:0] = cfg_i.poly_low[PW-1:0];
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask[i] = (DW'(i) < deg);
    end
    fb       = rem_q[IW'(deg - 1'b1)] ^ msg_bit_i;
    rem_next = ((rem_q << 1) ^ (fb ? poly_ext : '0)) & mask;
  end

  always_comb begin
    rem_d = rem_q;
    if (accept) begin
      rem_d = msg_last_i ? '0 : rem_next;
    end
  end

  assign q_wdata_o = {msg_bit_i, msg_last_i, deg, rem_next};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

endmodule

FILE: design/crc_back.sv
module crc_back #(
  parameter int unsigned MAX_DEGREE = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [MAX_DEGREE+$clog2(MAX_DEGREE+1)+1:0] q_rdata_i,
  input  logic q_empty_i,
  output logic q_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic code_bit_o,
  output logic is_check_bit_o,
  output logic code_last_o
);
  import crc_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  logic                  e_bit, e_last;
  logic [DW-1:0]         e_deg;
  logic [MAX_DEGREE-1:0] e_rem;

  logic [MAX_DEGREE-1:0] rem_q, rem_d;
  logic [DW-1:0]         cnt_q, cnt_d;
  logic                  valid_q, valid_d;
  logic                  bit_q, bit_d;
  logic                  check_q, check_d;
  logic                  last_q, last_d;
  logic                  load;

  assign {e_bit, e_last, e_deg, e_rem} = q_rdata_i;
  assign load = !valid_q || out_ready_i;

  always_comb begin
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    bit_d   = bit_q;
    check_d = check_q;
    last_d  = last_q;
    q_pop_o = 1'b0;
    if (load) begin
      priority if (cnt_q != '0) begin
        // serialize the remainder, most significant first
        valid_d = 1'b1;
        bit_d   = rem_q[IW'(cnt_q - 1'b1)];
        check_d = 1'b1;
        last_d  = (cnt_q == DW'(1));
        cnt_d   = cnt_q - 1'b1;
      end else if (!q_empty_i) begin
        q_pop_o = 1'b1;
        valid_d = 1'b1;
        bit_d   = e_bit;
        check_d = 1'b0;
        last_d  = 1'b0;
        if (e_last) begin
          rem_d = e_rem;
          cnt_d = e_deg;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    bit_q   <= bit_d;
    check_q <= check_d;
    last_q  <= last_d;
  end

  assign out_valid_o    = valid_q;
  assign code_bit_o     = bit_q;
  assign is_check_bit_o = check_q;
  assign code_last_o    = last_q;

endmodule

FILE: design/crc_codeword_generator.sv
// Serial CRC codeword generator with a programmable generator polynomial.
// Message bits enter one per cycle on msg_i while the queue is not full and
// appear unchanged on code_o; after the bit flagged last, the degree
// remainder bits follow, most significant first, with is_check_bit set and
// code_last on the final one. The remainder register updates once per bit;
// the output serializer emits one bit per cycle while code_o is ready, so
// a message of n bits leaves as n + degree output items. A two-entry queue
// sits between the update stage and the serializer, so input keeps flowing
// while check bits drain until that queue fills. Register 0 holds the
// coefficients below the implied leading one, register 1 the degree (0 acts
// as 1, values above MAX_DEGREE saturate); write them only while idle.
module crc_codeword_generator #(
  parameter int unsigned MAX_DEGREE = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [crc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  crc_in_if.sink                         msg_i,
  crc_out_if.source                      code_o
);
  import crc_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned EW = MAX_DEGREE + DW + 2;

  cfg_t          cfg_q;
  logic          q_push, q_pop, q_full, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly_low <= POLY_LOW_RESET;
      cfg_q.degree   <= DEGREE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLY_LOW:    cfg_q.poly_low <= cfg_wdata_i[POLY_W-1:0];
        REG_POLY_DEGREE: cfg_q.degree   <= cfg_wdata_i[DEGREE_W-1:0];
        default: ;
      endcase
    end
  end

  crc_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (msg_i.valid),
    .in_ready_o (msg_i.ready),
    .msg_bit_i  (msg_i.msg_bit),
    .msg_last_i (msg_i.msg_last),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_wdata_o  (q_wdata)
  );

  crc_fifo #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  crc_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_rdata_i      (q_rdata),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .out_valid_o    (code_o.valid),
    .out_ready_i    (code_o.ready),
    .code_bit_o     (code_o.code_bit),
    .is_check_bit_o (code_o.is_check_bit),
    .code_last_o    (code_o.code_last)
  );

endmodule

FILE: design/crc_checker.sv
module crc_protocol_checker (
  input logic       clk_i,
  input logic       rst_ni,
  crc_out_if.source code_o
);

  logic in_check_q;
  logic out_acc;

  assign out_acc = code_o.valid && code_o.ready;

  // inside a remainder run once its first check bit has left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_check_q <= 1'b0;
    end else if (out_acc && code_o.is_check_bit) begin
      in_check_q <= !code_o.code_last;
    end
  end

  a_last_is_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_o.valid && code_o.code_last |-> code_o.is_check_bit)
    else $error("codeword end on a message bit");

  a_check_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_o.valid && in_check_q |-> code_o.is_check_bit)
    else $error("message bit inside a remainder run");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_o.valid && !code_o.ready |=> code_o.valid && $stable(code_o.code_bit)
      && $stable(code_o.is_check_bit) && $stable(code_o.code_last))
    else $error("stalled output item changed");

endmodule

bind crc_codeword_generator crc_protocol_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .code_o (code_o)
);

FILE: tb/crc_checker.sv
`timescale 1ns / 100ps

module crc_checker #(
  parameter int unsigned MAX_DEGREE = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [crc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  crc_in_if                              msg_i,
  crc_out_if                             code_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import crc_pkg::*;

  typedef struct packed {
    logic code_bit;
    logic is_check_bit;
    logic code_last;
  } code_item_t;

  code_item_t        code_exp_q[$];
  cfg_t              cfg_q;
  logic [POLY_W-1:0] rem_q;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned       deg;
    logic [POLY_W-1:0] mask;
    logic              fb;
    code_item_t        got;
    code_item_t        want;
    if (!rst_ni) begin
      cfg_q.poly_low = POLY_LOW_RESET;
      cfg_q.degree   = DEGREE_RESET;
      rem_q          = '0;
      code_exp_q.delete();
    end else begin
      if (msg_i.valid && msg_i.ready) begin
        // degree zero acts as one, anything above the limit saturates
        if (cfg_q.degree == 0) begin
          deg = 1;
        end else if (cfg_q.degree > MAX_DEGREE) begin
          deg = MAX_DEGREE;
        end else begin
          deg = 32'(cfg_q.degree);
        end
        mask = {POLY_W{1'b1}} >> (POLY_W - deg);
        fb = rem_q[deg-1] ^ msg_i.msg_bit;
        rem_q = (rem_q << 1) & mask;
        if (fb) begin
          rem_q = rem_q ^ (cfg_q.poly_low & mask);
        end
        code_exp_q.insert(code_exp_q.size(), code_item_t'{msg_i.msg_bit, 1'b0, 1'b0});
        if (msg_i.msg_last) begin
          for (int k = deg - 1; k >= 0; k--) begin
            code_exp_q.insert(code_exp_q.size(), code_item_t'{rem_q[k], 1'b1, k == 0});
          end
          rem_q = '0;
        end
      end

      // a register write counts from the next item on
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_POLY_LOW) begin
          cfg_q.poly_low = cfg_wdata_i[POLY_W-1:0];
        end else if (cfg_idx_i == REG_POLY_DEGREE) begin
          cfg_q.degree = cfg_wdata_i[DEGREE_W-1:0];
        end
      end

      if (code_i.valid && code_i.ready) begin
        got = code_item_t'{code_i.code_bit, code_i.is_check_bit, code_i.code_last};
        if (code_exp_q.size() == 0) begin
          $error("code item %b arrived with nothing expected", got);
          fail_count_o++;
        end else begin
          want = code_exp_q.pop_front();
          if (got.code_bit !== want.code_bit) begin
            $error("code_bit: expected %0b, got %0b", want.code_bit, got.code_bit);
            fail_count_o++;
          end
          if (got.is_check_bit !== want.is_check_bit) begin
            $error("is_check_bit: expected %0b, got %0b", want.is_check_bit,
                   got.is_check_bit);
            fail_count_o++;
          end
          if (got.code_last !== want.code_last) begin
            $error("code_last: expected %0b, got %0b", want.code_last, got.code_last);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = code_exp_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import crc_pkg::*;

  localparam int unsigned MAX_DEGREE  = 32;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned RAND_ITEMS  = 80;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           idle_pct;
  logic                  hold_req;
  int unsigned           stall_cycles;

  crc_in_if  msg_if ();
  crc_out_if code_if ();

  crc_codeword_generator #(
    .MAX_DEGREE(MAX_DEGREE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .msg_i      (msg_if),
    .code_o     (code_if)
  );

  crc_checker #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .msg_i       (msg_if),
    .code_i      (code_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // one message bit per call, leaves at the falling edge after acceptance
  task automatic send_item(input logic b, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      msg_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    msg_if.valid    <= 1'b1;
    msg_if.msg_bit  <= b;
    msg_if.msg_last <= l;
    @(posedge clk_i);
    while (!msg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sends bits[len-1:0] msb first, last flag on the final bit
  task automatic send_word(input logic [31:0] bits, input int unsigned len);
    for (int i = len - 1; i >= 0; i--) begin
      send_item(bits[i], i == 0);
    end
  endtask

  // only while idle: every expected item back, then a short pause
  task automatic reconfigure(input logic [31:0] poly, input logic [31:0] degree_word);
    msg_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_POLY_LOW;
    cfg_wdata <= poly;
    @(negedge clk_i);
    cfg_idx   <= REG_POLY_DEGREE;
    cfg_wdata <= degree_word;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    code_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        code_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        code_if.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    @(posedge rst_ni);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((msg_if.valid && msg_if.ready) || (code_if.valid && code_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n_msgs;
    int unsigned len;
    logic [31:0] degree_word;
    msg_if.valid    = 1'b0;
    msg_if.msg_bit  = 1'b0;
    msg_if.msg_last = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_POLY_LOW;
    cfg_wdata       = '0;
    idle_pct        = 36;
    hold_req        = 1'b0;
    rst_ni          = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset polynomial and degree
    send_word(32'h1, 1);
    send_word(32'hB, 4);
    send_word(32'h0, 1);
    // degree zero behaves as degree one
    reconfigure(32'h1234_5678, 32'd0);
    send_word(32'h1, 1);
    send_word(32'h1, 2);
    reconfigure(32'hFFFF_FFFF, 32'd1);
    send_word(32'h3, 2);
    // degree 63 saturates, upper data bits are dropped
    reconfigure(32'h0, 32'hFFFF_FFFF);
    send_word(32'h6, 3);
    reconfigure(32'hFFFF_FFFF, 32'd32);
    send_word(32'h5, 3);
    // coefficients at or above the degree are ignored
    reconfigure(32'hABCD_EF07, 32'd8);
    send_word(32'h5, 3);
    reconfigure(32'h8000_0001, 32'd31);
    send_word(32'h1, 1);

    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      degree_word = $urandom;
      if ($urandom_range(9) == 0) begin
        degree_word[DEGREE_W-1:0] = DEGREE_W'($urandom_range(63));
      end else begin
        degree_word[DEGREE_W-1:0] = DEGREE_W'($urandom_range(32, 1));
      end
      if (phase == 1) begin
        degree_word[DEGREE_W-1:0] = 6'd32;
      end
      reconfigure($urandom, degree_word);
      idle_pct = (phase == 0) ? 0 : 36;
      n_msgs   = (phase == 0) ? 6 : $urandom_range(4, 1);
      for (int m = 0; m < n_msgs; m++) begin
        len = $urandom_range(12, 1);
        // long receiver hold-off while the sender keeps offering
        if (phase == 1 && m == 0) begin
          hold_req = 1'b1;
          len      = 24;
        end
        send_word($urandom, len);
        sent += len;
      end
      phase++;
    end

    msg_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/crc_pkg.sv
design/crc_if.sv
design/crc_fifo.sv
design/crc_front.sv
design/crc_back.sv
design/crc_codeword_generator.sv
design/crc_checker.sv
tb/crc_checker.sv
tb/tb_top.sv
